// ===== rtl/cjr_pkg.sv =====
package cjr_pkg;

    // Field and register widths fixed by the interface
    localparam int SAMPLE_W = 16;
    localparam int ACT_W    = 16;
    localparam int IDX_W    = 6;
    localparam int IWT_W    = 15;
    localparam int MASK_W   = 64;
    localparam int WT_W     = 16;
    localparam int JS_W     = 6;
    localparam int NC_W     = 7;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 64;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_INPUT_WEIGHT = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SIGN_MASK    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CYCLE_WEIGHT = 3'd2;
    localparam logic [CFG_AW-1:0] REG_JUMP_WEIGHT  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_JUMP_SIZE    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_NODE_COUNT   = 3'd5;

    // Q6.28 accumulator: input product plus up to three weighted neighbours
    localparam int ACC_W    = 35;
    localparam int FRAC     = 14;

    localparam logic [63:0] Q28_ONE = 64'd1 << 28;

    // Shift-subtract division, elaboration use only (table build)
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^y in Q28 for y below 4.0: series on y/16, then four squarings
    function automatic logic [63:0] exp_q28(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        z    = y >> 4;
        term = Q28_ONE;
        sum  = Q28_ONE;
        for (int n = 1; n <= 12; n++) begin
            term = udiv64((term * z) >> 28, 64'(n));
            sum  = sum + term;
        end
        for (int r = 0; r < 4; r++) begin
            sum = (sum * sum + (Q28_ONE >> 1)) >> 28;
        end
        return sum;
    endfunction

    // Table entry e: tanh(2e/entries) in Q1.14
    function automatic logic [ACT_W-1:0] tanh_entry(input int e, input int entries);
        logic [63:0] x;
        logic [63:0] big;
        logic [63:0] num;
        logic [63:0] den;
        x   = udiv64((64'(2 * e)) << 28, 64'(entries));
        big = exp_q28(x << 1);
        num = big - Q28_ONE;
        den = big + Q28_ONE;
        return ACT_W'(udiv64((num << FRAC) + (den >> 1), den));
    endfunction

endpackage

// ===== rtl/cjr_act.sv =====
// Activation: round Q6.28 to Q1.14, saturate, tanh lookup, restore sign.
// in_valid reaches out_valid through the registers v1_reg and v2_reg.
module cjr_act #(
    parameter int VALUE_WIDTH  = 16,
    parameter int TANH_ENTRIES = 1024,
    parameter int TAG_W        = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    input  logic signed [cjr_pkg::ACC_W-1:0]   in_acc,
    input  logic [TAG_W-1:0]                   in_tag,
    output logic                               out_valid,
    output logic signed [cjr_pkg::ACT_W-1:0]   out_value,
    output logic [TAG_W-1:0]                   out_tag
);

    localparam int QS_W = cjr_pkg::ACC_W - cjr_pkg::FRAC;
    localparam int QW   = (VALUE_WIDTH + 1 > QS_W) ? VALUE_WIDTH + 1 : QS_W;
    localparam int TIW  = $clog2(TANH_ENTRIES);
    localparam int MW   = VALUE_WIDTH + $clog2(TANH_ENTRIES + 1);

    localparam logic signed [QW-1:0] Q_HI =
        {{(QW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [QW-1:0] Q_LO = ~Q_HI;
    localparam logic signed [cjr_pkg::ACC_W-1:0] HALF =
        cjr_pkg::ACC_W'(1) << (cjr_pkg::FRAC - 1);

    // tanh table, built at elaboration
    logic [cjr_pkg::ACT_W-1:0] rom [TANH_ENTRIES];

    for (genvar g = 0; g < TANH_ENTRIES; g++) begin : g_rom
        localparam logic [cjr_pkg::ACT_W-1:0] ENTRY = cjr_pkg::tanh_entry(g, TANH_ENTRIES);
        assign rom[g] = ENTRY;
    end

    logic signed [cjr_pkg::ACC_W-1:0] t;
    logic signed [QS_W-1:0]           qs;
    logic signed [QW-1:0]             q;
    logic signed [QW-1:0]             q_sat;
    logic [QW-1:0]                    q_abs;

    logic [VALUE_WIDTH-1:0]           mag_reg;
    logic                             neg1_reg;
    logic [TAG_W-1:0]                 tag1_reg;
    logic                             v1_reg;

    logic [MW-1:0]                    scaled;
    logic [MW-1:0]                    idx_wide;
    logic [TIW-1:0]                   idx;

    logic [cjr_pkg::ACT_W-1:0]        rom_q_reg;
    logic                             neg2_reg;
    logic [TAG_W-1:0]                 tag2_reg;
    logic                             v2_reg;

    // round half up, floor, saturate
    always_comb begin
        t  = in_acc + HALF;
        qs = t[cjr_pkg::ACC_W-1:cjr_pkg::FRAC];
        q  = QW'(qs);
        if (q > Q_HI) begin
            q_sat = Q_HI;
        end else if (q < Q_LO) begin
            q_sat = Q_LO;
        end else begin
            q_sat = q;
        end
        q_abs = q_sat[QW-1] ? -q_sat : q_sat;
    end

    // table index from magnitude
    always_comb begin
        scaled   = MW'(mag_reg) * MW'(TANH_ENTRIES);
        idx_wide = scaled >> 15;
        if (idx_wide > MW'(TANH_ENTRIES - 1)) begin
            idx = TIW'(TANH_ENTRIES - 1);
        end else begin
            idx = idx_wide[TIW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg   <= q_abs[VALUE_WIDTH-1:0];
        neg1_reg  <= q_sat[QW-1];
        tag1_reg  <= in_tag;
        rom_q_reg <= rom[idx];
        neg2_reg  <= neg1_reg;
        tag2_reg  <= tag1_reg;
    end

    assign out_valid = v2_reg;
    assign out_value = neg2_reg ? -signed'(rom_q_reg) : signed'(rom_q_reg);
    assign out_tag   = tag2_reg;

endmodule

// ===== rtl/cycle_jump_reservoir_update_core.sv =====
// Channel   Dir  Fields (low bit up)                          Word accepted
// s_        in   tdata: sample[15:0]; tuser: clear_state      s_tvalid & s_tready
// m_        out  tdata: node_index[5:0], activation[21:6]     m_tvalid & m_tready
//                tlast: last
// cfg_      in   cfg_index, cfg_wdata                         cfg_wr_en
//
// A normal word runs each node through setup, three reads of the node RAM
// through one port and one multiplier, and the tanh stage, and then copies
// each new value back to the node RAM and emits it.
// A clear word, and reset, sweep the node RAM one entry a cycle, during which
// s_tready stays low.
// Node 0 is computed last; its jump rule needs N mod jump_size.
// A stall on m_ holds the emit sweep; no input word is taken until it ends.
module cycle_jump_reservoir_update_core #(
    parameter int MAX_NODES    = 64,
    parameter int VALUE_WIDTH  = 16,
    parameter int TANH_ENTRIES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write port
    input  logic                          cfg_wr_en,
    input  logic [cjr_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [cjr_pkg::CFG_DW-1:0]    cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // sample[15:0]
    input  logic                          s_tuser,   // clear_state
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // node_index[5:0], activation[21:6]
    output logic                          m_tlast
);

    localparam int IW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int EW  = ((CW > 7) ? CW : 7) + 1;
    localparam int NXW = (CW > cjr_pkg::NC_W) ? CW : cjr_pkg::NC_W;
    localparam int IXW = (IW > 6) ? IW : 7;
    localparam int AW  = cjr_pkg::ACC_W;
    localparam int VW  = cjr_pkg::ACT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_GATHER,
        S_ACT,
        S_ACT_WAIT,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    // configuration
    logic [cjr_pkg::IWT_W-1:0]        iw_reg;
    logic [cjr_pkg::MASK_W-1:0]       mask_reg;
    logic signed [cjr_pkg::WT_W-1:0]  cw_reg;
    logic signed [cjr_pkg::WT_W-1:0]  jw_reg;
    logic [cjr_pkg::JS_W-1:0]         k_reg;
    logic [cjr_pkg::NC_W-1:0]         nc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iw_reg   <= 15'd16384;
            mask_reg <= '0;
            cw_reg   <= 16'sd8192;
            jw_reg   <= 16'sd4096;
            k_reg    <= 6'd4;
            nc_reg   <= 7'd64;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cjr_pkg::REG_INPUT_WEIGHT: iw_reg   <= cfg_wdata[cjr_pkg::IWT_W-1:0];
                cjr_pkg::REG_SIGN_MASK:    mask_reg <= cfg_wdata;
                cjr_pkg::REG_CYCLE_WEIGHT: cw_reg   <= cfg_wdata[cjr_pkg::WT_W-1:0];
                cjr_pkg::REG_JUMP_WEIGHT:  jw_reg   <= cfg_wdata[cjr_pkg::WT_W-1:0];
                cjr_pkg::REG_JUMP_SIZE:    k_reg    <= cfg_wdata[cjr_pkg::JS_W-1:0];
                cjr_pkg::REG_NODE_COUNT:   nc_reg   <= cfg_wdata[cjr_pkg::NC_W-1:0];
                default: ;
            endcase
        end
    end

    // control and datapath registers
    state_t                           state_reg;
    logic [IW-1:0]                    clr_reg;
    logic [CW-1:0]                    n_reg;
    logic [CW-1:0]                    cnt_reg;
    logic [cjr_pkg::JS_W-1:0]         ph_reg;
    logic                             node0_reg;
    logic [IW-1:0]                    node_reg;
    logic [IW-1:0]                    emit_reg;
    logic [2:0]                       step_reg;
    logic signed [AW-1:0]             prod_reg;
    logic signed [AW-1:0]             acc_reg;
    logic [IW-1:0]                    slot_addr_reg [3];
    logic signed [cjr_pkg::WT_W-1:0]  slot_w_reg [3];
    logic [2:0]                       slot_en_reg;

    // multiply-accumulate pipeline
    logic                             rd_v_reg;
    logic signed [cjr_pkg::WT_W-1:0]  rd_w_reg;
    logic signed [2*VW-1:0]           prd_reg;
    logic                             prd_v_reg;

    // output word
    logic                             out_v_reg;
    logic [cjr_pkg::IDX_W-1:0]        out_idx_reg;
    logic [VW-1:0]                    out_act_reg;
    logic                             out_last_reg;

    // memories
    logic [VW-1:0]                    node_mem [MAX_NODES];
    logic [VW-1:0]                    next_mem [MAX_NODES];
    logic [VW-1:0]                    node_rdata_reg;
    logic [VW-1:0]                    next_rdata_reg;

    // activation unit
    logic                             act_in_v;
    logic                             act_out_v;
    logic signed [VW-1:0]             act_out_value;
    logic [IW-1:0]                    act_out_tag;

    cjr_act #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .TANH_ENTRIES (TANH_ENTRIES),
        .TAG_W        (IW)
    ) u_act (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (act_in_v),
        .in_acc    (acc_reg),
        .in_tag    (node_reg),
        .out_valid (act_out_v),
        .out_value (act_out_value),
        .out_tag   (act_out_tag)
    );

    assign act_in_v = (state_reg == S_ACT);

    // effective node count at accept
    logic [NXW-1:0] nc_x;
    logic [CW-1:0]  n_acc;
    always_comb begin
        nc_x = NXW'(nc_reg);
        if (nc_x > NXW'(MAX_NODES)) begin
            n_acc = CW'(MAX_NODES);
        end else begin
            n_acc = CW'(nc_x);
        end
    end

    // neighbour set of the node being set up
    logic               node0;
    logic [IW-1:0]      i_cur;
    logic               ph_zero;
    logic               kz;
    logic [EW-1:0]      i_e;
    logic [EW-1:0]      k_e;
    logic [EW-1:0]      n_e;
    logic [EW-1:0]      ik_e;
    logic               j1v;
    logic               j2v;
    logic               j2v_use;
    logic               pv;
    logic [IW-1:0]      j1;
    logic [IW-1:0]      j2;
    logic [IW-1:0]      p;
    logic [IXW-1:0]     i_x;
    logic               neg_in;

    always_comb begin
        node0   = (cnt_reg == n_reg);
        i_cur   = node0 ? '0 : IW'(cnt_reg);
        ph_zero = node0 || (ph_reg == '0);
        kz      = (k_reg == '0);
        i_e     = EW'(i_cur);
        k_e     = EW'(k_reg);
        n_e     = EW'(n_reg);
        ik_e    = i_e + k_e;
        // forward edge from a multiple of k
        j1v = !kz && ph_zero && (ik_e <= n_e);
        j1  = (ik_e == n_e) ? '0 : IW'(ik_e);
        // backward edge; node 0 is reached from N-k when k divides N
        if (node0) begin
            j2v = !kz && (k_e <= n_e) && (ph_reg == '0);
            j2  = IW'(n_e - k_e);
        end else begin
            j2v = !kz && ph_zero && (i_e >= k_e);
            j2  = IW'(i_e - k_e);
        end
        j2v_use = j2v && !(j1v && (j1 == j2));
        p       = node0 ? IW'(n_reg - CW'(1)) : IW'(i_cur - IW'(1));
        // jump edge replaces the cycle edge
        pv      = !((j1v && (j1 == p)) || (j2v && (j2 == p)));
        i_x     = IXW'(i_cur);
        neg_in  = (i_x < IXW'(64)) && mask_reg[i_x[5:0]];
    end

    // main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            out_v_reg <= 1'b0;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + IW'(1);
                    if (clr_reg == IW'(MAX_NODES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser) begin
                            clr_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end else if (n_acc != '0) begin
                            n_reg     <= n_acc;
                            cnt_reg   <= CW'(1);
                            ph_reg    <= (k_reg == 6'd1) ? 6'd0 : 6'd1;
                            prod_reg  <= AW'(signed'({1'b0, iw_reg}) * signed'(s_tdata));
                            state_reg <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    node0_reg        <= node0;
                    node_reg         <= i_cur;
                    acc_reg          <= neg_in ? -prod_reg : prod_reg;
                    slot_addr_reg[0] <= p;
                    slot_addr_reg[1] <= j1;
                    slot_addr_reg[2] <= j2;
                    slot_w_reg[0]    <= cw_reg;
                    slot_w_reg[1]    <= jw_reg;
                    slot_w_reg[2]    <= jw_reg;
                    slot_en_reg      <= {j2v_use, j1v, pv};
                    step_reg         <= '0;
                    if (!node0) begin
                        cnt_reg <= cnt_reg + CW'(1);
                        if (!kz) begin
                            ph_reg <= (ph_reg == k_reg - 6'd1) ? 6'd0 : ph_reg + 6'd1;
                        end
                    end
                    state_reg <= S_GATHER;
                end
                S_GATHER: begin
                    step_reg <= step_reg + 3'd1;
                    if (prd_v_reg) begin
                        acc_reg <= acc_reg + AW'(prd_reg);
                    end
                    if (step_reg == 3'd4) begin
                        state_reg <= S_ACT;
                    end
                end
                S_ACT: begin
                    state_reg <= S_ACT_WAIT;
                end
                S_ACT_WAIT: begin
                    if (act_out_v) begin
                        if (node0_reg) begin
                            emit_reg  <= '0;
                            state_reg <= S_EMIT_RD;
                        end else begin
                            state_reg <= S_SETUP;
                        end
                    end
                end
                S_EMIT_RD: begin
                    state_reg <= S_EMIT_OUT;
                end
                S_EMIT_OUT: begin
                    if (!out_v_reg) begin
                        out_v_reg    <= 1'b1;
                        out_idx_reg  <= cjr_pkg::IDX_W'(emit_reg);
                        out_act_reg  <= next_rdata_reg;
                        out_last_reg <= (CW'(emit_reg) == n_reg - CW'(1));
                    end else if (m_tready) begin
                        out_v_reg <= 1'b0;
                        if (out_last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            emit_reg  <= emit_reg + IW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // neighbour read, product, accumulate
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    assign rd_en   = (state_reg == S_GATHER) && (step_reg < 3'd3);
    assign rd_addr = slot_addr_reg[step_reg[1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            prd_v_reg <= 1'b0;
        end else begin
            rd_v_reg  <= rd_en && slot_en_reg[step_reg[1:0]];
            prd_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_w_reg <= slot_w_reg[step_reg[1:0]];
        prd_reg  <= rd_w_reg * signed'(node_rdata_reg);
    end

    // node RAM: cleared by sweep, refreshed during emit
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            node_mem[clr_reg] <= '0;
        end else if (state_reg == S_EMIT_OUT && !out_v_reg) begin
            node_mem[emit_reg] <= next_rdata_reg;
        end
        if (rd_en) begin
            node_rdata_reg <= node_mem[rd_addr];
        end
    end

    // new-value RAM
    always_ff @(posedge aclk) begin
        if (state_reg == S_ACT_WAIT && act_out_v) begin
            next_mem[act_out_tag] <= act_out_value;
        end
        if (state_reg == S_EMIT_RD) begin
            next_rdata_reg <= next_mem[emit_reg];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {2'b00, out_act_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== bench/cycle_jump_reservoir_update_core_tb.sv =====
`timescale 1ns / 1ps

module cycle_jump_reservoir_update_core_tb;

    localparam int NODES   = 64;
    localparam int ENTRIES = 1024;

    typedef struct packed {
        logic [cjr_pkg::IDX_W-1:0] node_index;
        logic [cjr_pkg::ACT_W-1:0] activation;
        logic                      last;
    } node_word_t;

    typedef struct {
        logic [15:0] sample;
        logic        clr;
        logic        check_fixed;
        logic [15:0] fixed_act0;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [cjr_pkg::CFG_AW-1:0] cfg_index = '0;
    logic [cjr_pkg::CFG_DW-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic m_tlast;

    cycle_jump_reservoir_update_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // predictor copy of registers and reservoir
    logic [14:0] p_in_wt;
    logic [63:0] p_mask;
    logic signed [15:0] p_cyc_wt, p_jump_wt;
    logic [5:0]  p_jump_sz;
    logic [6:0]  p_node_cnt;
    logic signed [15:0] p_nodes [NODES];
    logic [15:0] tanh_lut [ENTRIES];

    node_word_t expected_nodes[$];
    int mismatches = 0;
    int words_seen = 0;
    int steps_sent = 0;
    int clears_sent = 0;
    bit quiet_rx = 1'b0;
    bit rx_calm = 1'b0;

    // tanh table, own integer build
    function automatic longint unsigned exp_fixed(longint unsigned y);
        longint unsigned z, term, acc;
        z = y >> 4;
        term = 64'd1 << 28;
        acc = 64'd1 << 28;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * z) >> 28) / n;
            acc += term;
        end
        for (int r = 0; r < 4; r++) acc = (acc * acc + (64'd1 << 27)) >> 28;
        return acc;
    endfunction

    function automatic void build_lut();
        longint unsigned x, big, nu, de;
        for (int e = 0; e < ENTRIES; e++) begin
            x = ((64'(2 * e)) << 28) / ENTRIES;
            big = exp_fixed(2 * x);
            nu = big - (64'd1 << 28);
            de = big + (64'd1 << 28);
            tanh_lut[e] = 16'((nu * 16384 + de / 2) / de);
        end
    endfunction

    function automatic bit jump_edge(longint i, longint j, longint n, longint k);
        if (k <= 0) return 1'b0;
        if (i % k == 0 && i + k <= n && j == (i + k) % n) return 1'b1;
        if (j % k == 0 && j + k <= n && i == (j + k) % n) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [15:0] squash(longint acc);
        longint t, q;
        longint unsigned mag, ix;
        t = acc + 8192;
        q = t >>> 14;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        mag = (q < 0) ? -q : q;
        ix = (mag * ENTRIES) >> 15;
        if (ix > ENTRIES - 1) ix = ENTRIES - 1;
        return (q < 0) ? -tanh_lut[ix] : tanh_lut[ix];
    endfunction

    // one reservoir step: queues the node words it causes
    function automatic void predict_update(logic [15:0] smp, logic clr);
        longint n, k, acc, w;
        logic signed [15:0] fresh [NODES];
        node_word_t nw;
        if (clr) begin
            for (int i = 0; i < NODES; i++) p_nodes[i] = 0;
            return;
        end
        n = (p_node_cnt > NODES) ? NODES : p_node_cnt;
        if (n == 0) return;
        k = p_jump_sz;
        for (longint i = 0; i < n; i++) begin
            acc = longint'(p_in_wt) * longint'($signed(smp));
            if (i < 64 && p_mask[i]) acc = -acc;
            for (longint j = 0; j < n; j++) begin
                w = 0;
                if (jump_edge(i, j, n, k)) w = p_jump_wt;
                else if (j == (i + n - 1) % n) w = p_cyc_wt;
                acc += w * longint'(p_nodes[j]);
            end
            fresh[i] = squash(acc);
        end
        for (int i = 0; i < n; i++) begin
            p_nodes[i] = fresh[i];
            nw.node_index = 6'(i);
            nw.activation = fresh[i];
            nw.last = (i == n - 1);
            expected_nodes.insert(expected_nodes.size(), nw);
        end
    endfunction

    task automatic write_reg(logic [cjr_pkg::CFG_AW-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            cjr_pkg::REG_INPUT_WEIGHT: p_in_wt = val[14:0];
            cjr_pkg::REG_SIGN_MASK:    p_mask = val;
            cjr_pkg::REG_CYCLE_WEIGHT: p_cyc_wt = val[15:0];
            cjr_pkg::REG_JUMP_WEIGHT:  p_jump_wt = val[15:0];
            cjr_pkg::REG_JUMP_SIZE:    p_jump_sz = val[5:0];
            cjr_pkg::REG_NODE_COUNT:   p_node_cnt = val[6:0];
            default: ;
        endcase
    endtask

    // wait until all node words are in, then let a clear sweep finish
    task automatic drain_all();
        while (expected_nodes.size() != 0) @(negedge aclk);
        repeat (NODES + 20) @(negedge aclk);
    endtask

    // drive one word; idle beforehand unless calm
    task automatic send_word(logic [15:0] smp, logic clr, bit calm);
        if (!calm) begin
            while ($urandom_range(99) < 35) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tuser <= clr;
        predict_update(smp, clr);
        if (clr) clears_sent++; else steps_sent++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        // keep the drop of valid in its own cycle
        @(negedge aclk);
    endtask

    // receiver backpressure
    always @(negedge aclk) begin
        if (quiet_rx || rx_calm) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 35);
    end

    // result checker
    always @(posedge aclk) begin
        node_word_t got, exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            got.node_index = m_tdata[5:0];
            got.activation = m_tdata[21:6];
            got.last = m_tlast;
            words_seen++;
            if (expected_nodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected node word %h", m_tdata);
            end else begin
                exp_w = expected_nodes.pop_front();
                if (got !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx %0d act %h last %b, got %0d %h %b",
                                 exp_w.node_index, exp_w.activation, exp_w.last,
                                 got.node_index, got.activation, got.last);
                end
            end
        end
    end

    // fixed-time guard
    initial begin
        #20ms;
        $display("FAIL cycle_jump_reservoir_update_core");
        $finish;
    end

    stim_row_t rows[$];
    initial begin
        stim_row_t r;
        logic [15:0] first_act;
        build_lut();
        p_in_wt = 15'd16384;
        p_mask = '0;
        p_cyc_wt = 16'sd8192;
        p_jump_wt = 16'sd4096;
        p_jump_sz = 6'd4;
        p_node_cnt = 7'd64;
        for (int i = 0; i < NODES; i++) p_nodes[i] = 0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (NODES + 10) @(negedge aclk);

        // directed table; zero sample from reset gives all zeros
        rows = '{
            '{16'h0000, 1'b0, 1'b1, 16'h0000},
            '{16'h4000, 1'b0, 1'b0, 16'h0000},
            '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
            '{16'h8000, 1'b0, 1'b0, 16'h0000},
            '{16'h1234, 1'b1, 1'b0, 16'h0000},
            '{16'h0000, 1'b0, 1'b1, 16'h0000},
            '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
            '{16'h0001, 1'b0, 1'b0, 16'h0000}
        };
        foreach (rows[x]) begin
            r = rows[x];
            send_word(r.sample, r.clr, 1'b0);
            if (r.check_fixed) begin
                drain_all();
                first_act = p_nodes[0];
                if (first_act !== r.fixed_act0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("directed row %0d: node0 %h", x, first_act);
                end
            end
        end

        // extreme settings
        drain_all();
        write_reg(cjr_pkg::REG_INPUT_WEIGHT, 64'h7FFF);
        write_reg(cjr_pkg::REG_SIGN_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(cjr_pkg::REG_CYCLE_WEIGHT, 64'h7FFF);
        write_reg(cjr_pkg::REG_JUMP_WEIGHT, 64'h8000);
        write_reg(cjr_pkg::REG_JUMP_SIZE, 64'd63);
        write_reg(cjr_pkg::REG_NODE_COUNT, 64'd4);
        send_word(16'h7FFF, 1'b0, 1'b0);
        send_word(16'h8000, 1'b0, 1'b0);
        send_word(16'h4000, 1'b0, 1'b0);
        drain_all();
        write_reg(cjr_pkg::REG_JUMP_SIZE, 64'd2);
        write_reg(cjr_pkg::REG_CYCLE_WEIGHT, 64'h8000);
        write_reg(cjr_pkg::REG_JUMP_WEIGHT, 64'h7FFF);
        write_reg(cjr_pkg::REG_INPUT_WEIGHT, 64'd0);
        send_word(16'h1000, 1'b0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b0);
        drain_all();
        write_reg(cjr_pkg::REG_JUMP_SIZE, 64'd4);
        write_reg(cjr_pkg::REG_NODE_COUNT, 64'd4);
        write_reg(cjr_pkg::REG_INPUT_WEIGHT, 64'h2000);
        send_word(16'h3000, 1'b0, 1'b0);
        send_word(16'h5555, 1'b1, 1'b0);
        send_word(16'hAAAA, 1'b0, 1'b0);

        // random phases with random settings; mostly small reservoirs
        for (int ph = 0; ph < 12; ph++) begin
            drain_all();
            write_reg(cjr_pkg::REG_INPUT_WEIGHT, 64'($urandom_range(32767)));
            write_reg(cjr_pkg::REG_SIGN_MASK, {$urandom(), $urandom()});
            write_reg(cjr_pkg::REG_CYCLE_WEIGHT, 64'($urandom_range(65535)));
            write_reg(cjr_pkg::REG_JUMP_WEIGHT, 64'($urandom_range(65535)));
            write_reg(cjr_pkg::REG_JUMP_SIZE, 64'($urandom_range(63, 2)));
            write_reg(cjr_pkg::REG_NODE_COUNT,
                      (ph % 4 == 3) ? 64'd64 : 64'($urandom_range(16, 4)));
            rx_calm = (ph == 5);
            for (int t = 0; t < 20; t++)
                send_word(16'($urandom()), ($urandom_range(15) == 0), ph == 5);
            if (ph == 7) drain_all();
        end
        rx_calm = 1'b0;

        // closing wait
        quiet_rx = 1'b1;
        drain_all();
        $display("Covered %0d reservoir steps and %0d clears, %0d node words checked.",
                 steps_sent, clears_sent, words_seen);
        if (mismatches == 0 && expected_nodes.size() == 0)
            $display("PASS cycle_jump_reservoir_update_core");
        else
            $display("FAIL cycle_jump_reservoir_update_core");
        $finish;
    end

endmodule
